### hdl/ebwc_pkg.sv
`timescale 1ns / 1ps

package ebwc_pkg;

  // Field widths of the channels and the configuration register.
  localparam int KIND_W     = 3;
  localparam int LBA_W      = 15;
  localparam int LEFT_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int LINE_W     = 3;
  localparam int BLK_W      = 12;
  localparam int OFF_W      = 3;
  localparam int CNT_OUT_W  = 4;
  localparam int STAMP_W    = 32;

  // Widest index and tag that the parameter ranges allow.
  localparam int IDX_MAX_W  = 6;
  localparam int TAG_MAX_W  = 20;

  localparam int LINES_DEF             = 8;
  localparam int SECTORS_PER_BLOCK_DEF = 8;
  localparam int BLOCK_INDEX_BITS_DEF  = 12;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2048;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ       = 3'd0,
    KIND_WRITE      = 3'd1,
    KIND_FLUSH_SEL  = 3'd2,
    KIND_FLUSH_DONE = 3'd3,
    KIND_INVAL      = 3'd4
  } kind_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FLUSH = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SEARCH,
    S_DECIDE
  } state_t;

  // Running search result passed from cell to cell.
  typedef struct packed {
    logic                 vld;
    logic                 hit;
    logic                 hit_dirty;
    logic [IDX_MAX_W-1:0] hit_idx;
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
    logic                 cln_found;
    logic [IDX_MAX_W-1:0] cln_idx;
    logic [STAMP_W-1:0]   cln_stamp;
    logic                 drt_found;
    logic [IDX_MAX_W-1:0] drt_idx;
    logic [STAMP_W-1:0]   drt_stamp;
    logic [TAG_MAX_W-1:0] drt_tag;
    logic [TAG_MAX_W-1:0] fl_tag;
    logic                 fl_vd;
  } tok_t;

  // Metadata update broadcast to all cells when a step commits.
  typedef struct packed {
    logic                 wr;
    logic                 alloc;
    logic [IDX_MAX_W-1:0] wr_idx;
    logic [TAG_MAX_W-1:0] tag;
    logic [STAMP_W-1:0]   stamp;
    logic                 clr;
    logic [IDX_MAX_W-1:0] clr_idx;
    logic                 clear_all;
  } upd_t;

endpackage

### hdl/ebwc_in_if.sv
`timescale 1ns / 1ps

interface ebwc_in_if
  import ebwc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [LBA_W-1:0]  lba;
  logic [LEFT_W-1:0] sectors_left;
  logic              flush_ok;

  modport source (output valid, kind, lba, sectors_left, flush_ok, input ready);
  modport sink   (input valid, kind, lba, sectors_left, flush_ok, output ready);
endinterface

### hdl/ebwc_out_if.sv
`timescale 1ns / 1ps

interface ebwc_out_if
  import ebwc_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 from_line;
  logic [LINE_W-1:0]    line;
  logic [BLK_W-1:0]     block_index;
  logic [OFF_W-1:0]     sector_offset;
  logic                 fill_needed;
  logic [CNT_OUT_W-1:0] dirty_count;
  logic                 failed;

  modport source (output valid, status, from_line, line, block_index, sector_offset,
                  fill_needed, dirty_count, failed, input ready);
  modport sink   (input valid, status, from_line, line, block_index, sector_offset,
                  fill_needed, dirty_count, failed, output ready);
endinterface

### hdl/ebwc_cell.sv
`timescale 1ns / 1ps

module ebwc_cell
  import ebwc_pkg::*;
#(
  parameter int TAG_W = BLOCK_INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_MAX_W-1:0] cell_idx,
  input  logic [TAG_W-1:0]     req_tag,
  input  logic [IDX_MAX_W-1:0] flush_idx,
  input  upd_t                 upd,
  input  logic                 upd_en,
  input  tok_t                 tok_in,
  output tok_t                 tok_out,
  output logic                 line_vd
);

  logic [TAG_W-1:0]   tag_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               valid_r;
  logic               dirty_r;
  tok_t               tok_r;
  tok_t               tok_nxt;

  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.hit && valid_r && (tag_r == req_tag)) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_idx   = cell_idx;
      tok_nxt.hit_dirty = dirty_r;
    end
    if (!tok_in.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = cell_idx;
    end
    // Strict compare keeps the lower index on equal stamps.
    if (valid_r && !dirty_r && (!tok_in.cln_found || (stamp_r < tok_in.cln_stamp))) begin
      tok_nxt.cln_found = 1'b1;
      tok_nxt.cln_idx   = cell_idx;
      tok_nxt.cln_stamp = stamp_r;
    end
    if (valid_r && dirty_r && (!tok_in.drt_found || (stamp_r < tok_in.drt_stamp))) begin
      tok_nxt.drt_found = 1'b1;
      tok_nxt.drt_idx   = cell_idx;
      tok_nxt.drt_stamp = stamp_r;
      tok_nxt.drt_tag   = TAG_MAX_W'(tag_r);
    end
    if (flush_idx == cell_idx) begin
      tok_nxt.fl_tag = TAG_MAX_W'(tag_r);
      tok_nxt.fl_vd  = valid_r && dirty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      stamp_r <= '0;
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
    end else if (upd_en) begin
      if (upd.clear_all) begin
        tag_r   <= '0;
        stamp_r <= '0;
        valid_r <= 1'b0;
        dirty_r <= 1'b0;
      end else begin
        if (upd.wr && (upd.wr_idx == cell_idx)) begin
          stamp_r <= upd.stamp;
          dirty_r <= 1'b1;
          if (upd.alloc) begin
            valid_r <= 1'b1;
            tag_r   <= upd.tag[TAG_W-1:0];
          end
        end
        if (upd.clr && (upd.clr_idx == cell_idx)) begin
          dirty_r <= 1'b0;
        end
      end
    end
  end

  assign tok_out = tok_r;
  assign line_vd = valid_r && dirty_r;

endmodule

### hdl/erase_block_writeback_cache_policy.sv
`timescale 1ns / 1ps

// Replacement policy and line metadata for a write-back cache of flash erase blocks.
// Requests arrive on in_chan (read, write, flush select, flush done, invalidate), and
// every request yields exactly one result on out_chan; both are valid/ready channels
// and a transfer happens on a clock edge with valid and ready high.
// sector_limit is written through cfg_we/cfg_wdata; the user must do so only while no
// request is in flight, as the block does not enforce it. Each line lives in one cell
// of a chain; a search token walks the chain one cell per cycle, collecting the hit,
// the first free line and the oldest clean and dirty lines. A request is taken only
// in the idle state; the block then divides the address, runs the token down the
// chain, decides and registers the result before it takes the next request, so the
// cell chain length sets the throughput. When the receiver stalls, the result waits
// in the output register and the block holds the finished step in its commit state,
// keeping in_chan.ready low. Synchronous active-low reset clears all lines, the age
// clock, the failed flag and the flush pointer, and loads sector_limit with 2048.
module erase_block_writeback_cache_policy
  import ebwc_pkg::*;
#(
  parameter int LINES             = LINES_DEF,
  parameter int SECTORS_PER_BLOCK = SECTORS_PER_BLOCK_DEF,
  parameter int BLOCK_INDEX_BITS  = BLOCK_INDEX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  ebwc_in_if.sink            in_chan,
  ebwc_out_if.source         out_chan
);

  localparam int IW     = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CNT_W  = $clog2(LINES + 1);
  localparam int TAG_W  = BLOCK_INDEX_BITS;
  localparam int OW     = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
  // Exact division by a constant through a reciprocal multiply.
  localparam int DIV_L  = $clog2(SECTORS_PER_BLOCK);
  localparam int DIV_S  = LBA_W + DIV_L;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_S) + SECTORS_PER_BLOCK - 1) / SECTORS_PER_BLOCK;
  localparam int MW     = LBA_W + 2;
  localparam int PW     = LBA_W + MW;
  localparam int QM_W   = LBA_W + 7;

  state_t state_r, state_nxt;

  logic [LIMIT_W-1:0] limit_r;
  logic [KIND_W-1:0]  kind_r;
  logic [LBA_W-1:0]   lba_r;
  logic               ok_r;
  logic               err_r;
  logic [LBA_W-1:0]   q_r;
  logic [OW-1:0]      off_r;
  logic               launch_r;
  tok_t               res_r;

  logic [STAMP_W-1:0] age_r, age_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               failed_r, failed_nxt;
  logic [IW-1:0]      flush_line_r, flush_line_nxt;

  logic [PW-1:0]      prod;
  logic [QM_W-1:0]    qm;
  logic [LIMIT_W:0]   end_sum;
  logic               range_err;
  logic [TAG_W-1:0]   req_tag;
  logic               in_xfer;
  logic               commit;
  upd_t               upd;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic                 from_line_r, from_line_nxt;
  logic [LINE_W-1:0]    line_r, line_nxt;
  logic [BLK_W-1:0]     blk_r, blk_nxt;
  logic [OFF_W-1:0]     offset_r, offset_nxt;
  logic                 fill_r, fill_nxt;

  tok_t                 chain [LINES+1];
  logic [LINES-1:0]     line_vd;

  assign in_xfer = in_chan.valid && in_chan.ready;
  assign commit  = (state_r == S_DECIDE) && (!out_valid_r || out_chan.ready);

  // A request is in range when it is non-empty and ends at or below the limit.
  assign end_sum   = {1'b0, in_chan.sectors_left} + (LIMIT_W + 1)'(in_chan.lba);
  assign range_err = (in_chan.sectors_left == '0) || (end_sum > {1'b0, limit_r});

  assign prod    = PW'(lba_r) * PW'(MW'(DIV_M));
  assign qm      = QM_W'(q_r) * QM_W'(SECTORS_PER_BLOCK);
  assign req_tag = TAG_W'(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= in_chan.kind;
      lba_r  <= in_chan.lba;
      ok_r   <= in_chan.flush_ok;
      err_r  <= range_err;
    end
    if (state_r == S_DIV) begin
      q_r <= LBA_W'(prod >> DIV_S);
    end
    off_r <= OW'(lba_r - LBA_W'(qm));
    if ((state_r == S_SEARCH) && chain[LINES].vld) begin
      res_r <= chain[LINES];
    end
  end

  // Cell chain
  assign chain[0] = '{vld: launch_r, default: '0};

  for (genvar i = 0; i < LINES; i++) begin : g_cell
    ebwc_cell #(
      .TAG_W (TAG_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_MAX_W'(i)),
      .req_tag   (req_tag),
      .flush_idx (IDX_MAX_W'(flush_line_r)),
      .upd       (upd),
      .upd_en    (commit),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1]),
      .line_vd   (line_vd[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_DIV;
      S_DIV:    state_nxt = S_SEARCH;
      S_SEARCH: if (chain[LINES].vld) state_nxt = S_DECIDE;
      S_DECIDE: if (commit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outcome of the step and the metadata update it commits
  always_comb begin
    status_nxt     = ST_OK;
    from_line_nxt  = 1'b0;
    line_nxt       = '0;
    blk_nxt        = '0;
    offset_nxt     = '0;
    fill_nxt       = 1'b0;
    age_nxt        = age_r;
    cnt_nxt        = cnt_r;
    failed_nxt     = failed_r;
    flush_line_nxt = flush_line_r;
    upd            = '0;
    case (kind_r)
      KIND_READ: begin
        if (err_r) begin
          status_nxt = ST_RANGE;
        end else begin
          blk_nxt    = BLK_W'(req_tag);
          offset_nxt = OFF_W'(off_r);
          if (res_r.hit) begin
            line_nxt      = LINE_W'(res_r.hit_idx);
            from_line_nxt = res_r.hit_dirty;
          end
        end
      end
      KIND_WRITE: begin
        if (err_r) begin
          status_nxt = ST_RANGE;
        end else if (!res_r.hit && !res_r.free_found && !res_r.cln_found) begin
          status_nxt = ST_BUSY;
        end else begin
          blk_nxt    = BLK_W'(req_tag);
          offset_nxt = OFF_W'(off_r);
          age_nxt    = age_r + 1'b1;
          upd.wr     = 1'b1;
          upd.tag    = TAG_MAX_W'(req_tag);
          upd.stamp  = age_r + 1'b1;
          if (res_r.hit) begin
            upd.wr_idx = res_r.hit_idx;
          end else if (res_r.free_found) begin
            upd.wr_idx = res_r.free_idx;
            upd.alloc  = 1'b1;
          end else begin
            upd.wr_idx = res_r.cln_idx;
            upd.alloc  = 1'b1;
          end
          fill_nxt = upd.alloc;
          line_nxt = LINE_W'(upd.wr_idx);
          if (!(res_r.hit && res_r.hit_dirty)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      KIND_FLUSH_SEL: begin
        if (!res_r.drt_found) begin
          status_nxt = ST_NO_FLUSH;
        end else begin
          flush_line_nxt = IW'(res_r.drt_idx);
          line_nxt       = LINE_W'(res_r.drt_idx);
          blk_nxt        = BLK_W'(res_r.drt_tag);
        end
      end
      KIND_FLUSH_DONE: begin
        line_nxt = LINE_W'(flush_line_r);
        blk_nxt  = BLK_W'(res_r.fl_tag);
        if (ok_r) begin
          upd.clr     = 1'b1;
          upd.clr_idx = IDX_MAX_W'(flush_line_r);
          if (res_r.fl_vd) begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end else begin
          failed_nxt = 1'b1;
        end
      end
      KIND_INVAL: begin
        upd.clear_all = 1'b1;
        age_nxt       = '0;
        cnt_nxt       = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launch_r     <= 1'b0;
      age_r        <= '0;
      cnt_r        <= '0;
      failed_r     <= 1'b0;
      flush_line_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= (state_r == S_DIV);
      if (commit) begin
        age_r        <= age_nxt;
        cnt_r        <= cnt_nxt;
        failed_r     <= failed_nxt;
        flush_line_r <= flush_line_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r    <= status_nxt;
      from_line_r <= from_line_nxt;
      line_r      <= line_nxt;
      blk_r       <= blk_nxt;
      offset_r    <= offset_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // Port outputs
  always_comb begin
    in_chan.ready          = (state_r == S_IDLE);
    out_chan.valid         = out_valid_r;
    out_chan.status        = status_r;
    out_chan.from_line     = from_line_r;
    out_chan.line          = line_r;
    out_chan.block_index   = blk_r;
    out_chan.sector_offset = offset_r;
    out_chan.fill_needed   = fill_r;
    out_chan.dirty_count   = CNT_OUT_W'(cnt_r);
    out_chan.failed        = failed_r;
  end

  // The kept dirty count always matches the dirty lines held in the cells.
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(line_vd))
    else $error("dirty count out of step with the cells");

  a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain[LINES].vld |-> (state_r == S_SEARCH))
    else $error("search token left the chain outside the search state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_DIV) && !out_valid_r || (state_r == S_DIV))
    else $error("transfer did not start a step");

  a_flush_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(flush_line_r) < LINES)
    else $error("flush pointer beyond the last line");

  a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && (state_r == S_IDLE))
    else $error("committed step did not present a result");

endmodule
